// ===== sv/mma_pkg.sv =====
// Shared types and constants of the matrix multiply-accumulate unit.
package mma_pkg;

	localparam int CMD_W     = 3;
	localparam int INDEX_W   = 8;
	localparam int VALUE_W   = 48;
	localparam int DIM_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_WR_A    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_B    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_C    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RD_C    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_a;       // host write of A, gated by index range in the datapath
		logic wr_b;
		logic wr_c;
		logic rd_c;       // host read of C
		logic mac_rd;     // read A, B and C operands
		logic mac_mul;    // register the product
		logic mac_wr;     // saturating add, write C back
		logic load_rd;    // load output register with read data
		logic load_done;  // load output register with a done result
	} dp_cmd_t;

endpackage

// ===== sv/mma_ctrl.sv =====
// Controller of the matrix multiply-accumulate unit: config, sequencing, address counters.
module mma_ctrl #(
	parameter int MAX_DIM = 16,
	parameter int AW      = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mma_pkg::DIM_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mma_pkg::CMD_W-1:0]      cmd,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output mma_pkg::dp_cmd_t               dp_cmd,
	output logic [AW-1:0]                  a_addr,
	output logic [AW-1:0]                  b_addr,
	output logic [AW-1:0]                  c_addr
);
	import mma_pkg::*;

	localparam int DIM_RST = (MAX_DIM < 16) ? MAX_DIM : 16;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_RD     = 6'b000010,
		ST_MAC_RD = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_MAC_WR = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [DIM_W-1:0] rows_m_q, cols_n_q, inner_k_q;
	logic [DIM_W-1:0] cfg_sat;
	logic [DIM_W-1:0] i_q, p_q, j_q;
	logic [AW-1:0]    a_addr_q, b_addr_q, c_addr_q, c_base_q;
	logic             out_valid_q;
	logic             accept, out_free, start;
	logic             i_end, p_end, j_end, dim_zero;

	assign cfg_sat = (32'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= DIM_W'(DIM_RST);
			cols_n_q  <= DIM_W'(DIM_RST);
			inner_k_q <= DIM_W'(DIM_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_M:  rows_m_q  <= cfg_sat;
				REG_COLS_N:  cols_n_q  <= cfg_sat;
				REG_INNER_K: inner_k_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	assign dim_zero = (rows_m_q == '0) || (cols_n_q == '0) || (inner_k_q == '0);
	assign i_end    = (i_q == rows_m_q - DIM_W'(1));
	assign p_end    = (p_q == inner_k_q - DIM_W'(1));
	assign j_end    = (j_q == cols_n_q - DIM_W'(1));

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_WR_A: dp_cmd.wr_a = 1'b1;
						CMD_WR_B: dp_cmd.wr_b = 1'b1;
						CMD_WR_C: dp_cmd.wr_c = 1'b1;
						CMD_COMPUTE: begin
							start   = 1'b1;
							state_d = dim_zero ? ST_DONE : ST_MAC_RD;
						end
						CMD_RD_C: begin
							dp_cmd.rd_c = 1'b1;
							state_d     = ST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				if (out_free) begin
					dp_cmd.load_rd = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_MAC_RD: begin
				dp_cmd.mac_rd = 1'b1;
				state_d       = ST_MUL;
			end
			ST_MUL: begin
				dp_cmd.mac_mul = 1'b1;
				state_d        = ST_MAC_WR;
			end
			ST_MAC_WR: begin
				dp_cmd.mac_wr = 1'b1;
				state_d       = (i_end && p_end && j_end) ? ST_DONE : ST_MAC_RD;
			end
			ST_DONE: begin
				if (out_free) begin
					dp_cmd.load_done = 1'b1;
					state_d          = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.load_rd || dp_cmd.load_done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Loop order j, p, i; addresses run as counters instead of index products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			p_q      <= '0;
			j_q      <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			c_addr_q <= '0;
			c_base_q <= '0;
		end else if (start) begin
			i_q      <= '0;
			p_q      <= '0;
			j_q      <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			c_addr_q <= '0;
			c_base_q <= '0;
		end else if (dp_cmd.mac_wr) begin
			if (!i_end) begin
				i_q      <= i_q + DIM_W'(1);
				a_addr_q <= a_addr_q + AW'(1);
				c_addr_q <= c_addr_q + AW'(1);
			end else begin
				i_q      <= '0;
				b_addr_q <= b_addr_q + AW'(1);
				if (!p_end) begin
					p_q      <= p_q + DIM_W'(1);
					a_addr_q <= a_addr_q + AW'(1);
					c_addr_q <= c_base_q;
				end else begin
					// next column of C
					p_q      <= '0;
					j_q      <= j_q + DIM_W'(1);
					a_addr_q <= '0;
					c_addr_q <= c_addr_q + AW'(1);
					c_base_q <= c_addr_q + AW'(1);
				end
			end
		end
	end

	assign a_addr = a_addr_q;
	assign b_addr = b_addr_q;
	assign c_addr = c_addr_q;

endmodule

// ===== sv/mma_dp.sv =====
// Datapath of the matrix multiply-accumulate unit: A, B, C memories, MAC and output register.
module mma_dp #(
	parameter int MAX_DIM   = 16,
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS  = 48,
	parameter int AW        = 8
) (
	input  logic                                clk,
	input  mma_pkg::dp_cmd_t                    dp_cmd,
	input  logic [mma_pkg::INDEX_W-1:0]         elem_index,
	input  logic signed [mma_pkg::VALUE_W-1:0]  elem_value,
	input  logic [AW-1:0]                       a_addr,
	input  logic [AW-1:0]                       b_addr,
	input  logic [AW-1:0]                       c_addr,
	output logic signed [mma_pkg::VALUE_W-1:0]  out_value,
	output logic                                compute_done
);
	import mma_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int PW    = 2 * ELEM_BITS;
	localparam int XW    = (ACC_BITS > VALUE_W) ? ACC_BITS : VALUE_W;
	localparam int SW    = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;

	localparam logic signed [VALUE_W-1:0] E_HI =
		{{(VALUE_W-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] E_LO = ~E_HI;
	localparam logic signed [XW-1:0] CX_HI =
		{{(XW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [XW-1:0] CX_LO = ~CX_HI;
	localparam logic signed [SW-1:0] S_HI =
		{{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] S_LO = ~S_HI;

	logic signed [ELEM_BITS-1:0] a_mem [0:DEPTH-1];
	logic signed [ELEM_BITS-1:0] b_mem [0:DEPTH-1];
	logic signed [ACC_BITS-1:0]  c_mem [0:DEPTH-1];

	logic signed [ELEM_BITS-1:0] a_rd_q, b_rd_q;
	logic signed [ACC_BITS-1:0]  c_rd_q;
	logic signed [PW-1:0]        prod_q;
	logic                        rd_ok_q;
	logic signed [VALUE_W-1:0]   out_value_q;
	logic                        out_done_q;

	logic                        in_range;
	logic [AW-1:0]               host_addr;
	logic signed [ELEM_BITS-1:0] elem_sat;
	logic signed [XW-1:0]        val_ext;
	logic signed [ACC_BITS-1:0]  c_host_w;
	logic signed [SW-1:0]        sum;
	logic signed [ACC_BITS-1:0]  c_mac_w;
	logic signed [XW-1:0]        c_rd_ext;
	logic                        c_we;
	logic [AW-1:0]               c_waddr, c_raddr;
	logic signed [ACC_BITS-1:0]  c_wdata;

	assign in_range  = (32'(elem_index) < DEPTH);
	assign host_addr = AW'(elem_index);

	always_comb begin
		if (elem_value > E_HI)
			elem_sat = E_HI[ELEM_BITS-1:0];
		else if (elem_value < E_LO)
			elem_sat = E_LO[ELEM_BITS-1:0];
		else
			elem_sat = elem_value[ELEM_BITS-1:0];
	end

	assign val_ext = XW'(elem_value);

	always_comb begin
		if (val_ext > CX_HI)
			c_host_w = CX_HI[ACC_BITS-1:0];
		else if (val_ext < CX_LO)
			c_host_w = CX_LO[ACC_BITS-1:0];
		else
			c_host_w = val_ext[ACC_BITS-1:0];
	end

	// exact sum, then clamp to the C range
	assign sum = SW'(c_rd_q) + SW'(prod_q);

	always_comb begin
		if (sum > S_HI)
			c_mac_w = S_HI[ACC_BITS-1:0];
		else if (sum < S_LO)
			c_mac_w = S_LO[ACC_BITS-1:0];
		else
			c_mac_w = sum[ACC_BITS-1:0];
	end

	assign c_we    = (dp_cmd.wr_c && in_range) || dp_cmd.mac_wr;
	assign c_waddr = dp_cmd.mac_wr ? c_addr : host_addr;
	assign c_wdata = dp_cmd.mac_wr ? c_mac_w : c_host_w;
	assign c_raddr = dp_cmd.mac_rd ? c_addr : host_addr;

	always_ff @(posedge clk) begin
		if (dp_cmd.wr_a && in_range)
			a_mem[host_addr] <= elem_sat;
		if (dp_cmd.mac_rd)
			a_rd_q <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.wr_b && in_range)
			b_mem[host_addr] <= elem_sat;
		if (dp_cmd.mac_rd)
			b_rd_q <= b_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			c_mem[c_waddr] <= c_wdata;
		if (dp_cmd.mac_rd || dp_cmd.rd_c)
			c_rd_q <= c_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.mac_mul)
			prod_q <= a_rd_q * b_rd_q;
		if (dp_cmd.rd_c)
			rd_ok_q <= in_range;
	end

	assign c_rd_ext = XW'(c_rd_q);

	always_ff @(posedge clk) begin
		if (dp_cmd.load_rd) begin
			out_value_q <= rd_ok_q ? c_rd_ext[VALUE_W-1:0] : '0;
			out_done_q  <= 1'b0;
		end else if (dp_cmd.load_done) begin
			out_value_q <= '0;
			out_done_q  <= 1'b1;
		end
	end

	assign out_value    = out_value_q;
	assign compute_done = out_done_q;

endmodule

// ===== sv/matrix_multiply_accumulate_unit.sv =====
// Top level of the matrix multiply-accumulate unit, C += A*B, column-major stores.
//
// Input stream (s_*): one command per transfer, s_tuser the command, s_tdata
// the element index and value. Writes of A, B and C are taken back to back;
// they give no result and are taken while a result waits on the output.
// Read of C: C is read into a register, then loaded into the output register
// once the output is free; the input stays blocked until the result is loaded.
// Compute: runs m*n*k multiply-accumulates, each as a read, a multiply, then
// an add and write back, after which the done result is loaded once the
// output is free. Dimensions of zero skip straight to done.
// Output stream (m_*): m_tdata the C value (zero on done), m_tuser the done
// flag. A stalled output holds its result; a read or compute waits for it.
// Config port: cfg_we, cfg_index, cfg_data write m, n, k; values above
// MAX_DIM saturate. Write only while idle.
// Reset: dimensions go to MAX_DIM, at most 16, control returns to idle, output
// empty. The A, B and C memories are not cleared and hold garbage until written.
module matrix_multiply_accumulate_unit #(
	parameter int MAX_DIM   = 16,
	parameter int ELEM_BITS = 16,
	parameter int ACC_BITS  = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mma_pkg::DIM_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [55:0]                       s_tdata,  // elem_index[7:0], elem_value[55:8]
	input  logic [mma_pkg::CMD_W-1:0]         s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,  // out_value
	output logic                              m_tuser   // compute_done
);
	import mma_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	dp_cmd_t                    dp_cmd;
	logic [AW-1:0]              a_addr, b_addr, c_addr;
	logic signed [VALUE_W-1:0]  out_value;
	logic                       compute_done;

	mma_ctrl #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cmd       (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.dp_cmd    (dp_cmd),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.c_addr    (c_addr)
	);

	mma_dp #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS),
		.ACC_BITS  (ACC_BITS),
		.AW        (AW)
	) u_dp (
		.clk          (clk),
		.dp_cmd       (dp_cmd),
		.elem_index   (s_tdata[7:0]),
		.elem_value   (s_tdata[55:8]),
		.a_addr       (a_addr),
		.b_addr       (b_addr),
		.c_addr       (c_addr),
		.out_value    (out_value),
		.compute_done (compute_done)
	);

	assign m_tdata = out_value;
	assign m_tuser = compute_done;

endmodule
